### hdl/sha1_byte_stream_hasher_core_defines.svh
//------------------------------------------------------------------------------
// SHA-1 byte stream hasher assertion macros
// Shared property shorthands used by the port-level checker.
//------------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sha1 checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sha1 checker: next-cycle property failed");

`endif

### hdl/sha1_pkg.sv
//------------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types, op codes and hash constants.
//------------------------------------------------------------------------------
package sha1_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int WORDS       = BLOCK_BYTES / 4;
    localparam int ROUNDS      = 80;

    // Request kinds carried on the input side.
    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_DIGEST  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef logic [31:0]      word_t;
    typedef logic [4:0][31:0] hash_t;

    localparam hash_t SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                 32'hefcdab89, 32'h67452301};

    localparam logic [3:0][31:0] SHA1_K = {32'hCA62C1D6, 32'h8F1BBCDC,
                                           32'h6ED9EBA1, 32'h5A827999};

    // Controls from the sequencer to the round unit.
    typedef struct packed {
        logic       load_vars;
        logic       shift_in;
        logic       round_en;
        logic [1:0] phase;
    } sha1_ctrl_t;

endpackage

### hdl/sha1_ram.sv
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sha1_round.sv
//------------------------------------------------------------------------------
// SHA-1 round unit
// Working variables and a sixteen-word rolling message schedule; one round
// per enabled cycle.
//------------------------------------------------------------------------------
module sha1_round
    import sha1_pkg::*;
(
    input  logic       clk,
    input  sha1_ctrl_t ctrl,
    input  hash_t      base,
    input  word_t      word_in,
    output hash_t      vars
);

    hash_t               vars_reg;
    hash_t               vars_next;
    logic [15:0][31:0]   sched_reg;
    word_t               va, vb, vc, vd, ve;
    word_t               f_val;
    word_t               t_val;
    word_t               w_mix;
    word_t               w_new;

    assign va = vars_reg[0];
    assign vb = vars_reg[1];
    assign vc = vars_reg[2];
    assign vd = vars_reg[3];
    assign ve = vars_reg[4];

    always_comb
    begin
        case (ctrl.phase)
            2'd0:    f_val = (vb & vc) | (~vb & vd);
            2'd2:    f_val = (vb & vc) | (vb & vd) | (vc & vd);
            default: f_val = vb ^ vc ^ vd;
        endcase
    end

    assign t_val = {va[26:0], va[31:27]} + f_val + ve + SHA1_K[ctrl.phase] + sched_reg[0];

    // The schedule word sixteen rounds ahead.
    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        vars_next = vars_reg;
        if (ctrl.load_vars)
        begin
            vars_next = base;
        end
        else if (ctrl.round_en)
        begin
            vars_next = {vd, vc, {vb[1:0], vb[31:2]}, va, t_val};
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        if (ctrl.shift_in || ctrl.round_en)
        begin
            sched_reg <= {(ctrl.round_en ? w_new : word_in), sched_reg[15:1]};
        end
    end

    assign vars = vars_reg;

endmodule

### hdl/sha1_byte_stream_hasher_core.sv
// An absorb request is taken while idle; the 64th byte of a block starts a compression of that block.
// A digest request compresses one or two padded blocks, then delivers five digest words.
// Each compression runs on the single round unit: a load phase, 80 rounds, then a final add.
// Reset (rst_n low, asynchronous) loads the SHA-1 initial values and clears the counts.
// The block buffer needs no clearing; only bytes written since the last block are read.
//------------------------------------------------------------------------------
// SHA-1 byte stream hasher core
// Absorbs one message byte per request and reports the SHA-1 digest on demand.
//------------------------------------------------------------------------------
module sha1_byte_stream_hasher_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Which block the compression is working on.
    localparam logic [1:0] KIND_ABS = 2'd0;   // a full message block
    localparam logic [1:0] KIND_PAD = 2'd1;   // pending bytes plus padding
    localparam logic [1:0] KIND_LEN = 2'd2;   // zero block carrying the length only

    localparam logic [6:0] LOAD_END   = 7'(WORDS);
    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

    logic [2:0]  state_reg, state_next;
    logic [1:0]  kind_reg, kind_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic [2:0]  oidx_reg, oidx_next;
    hash_t       cv_reg, cv_next;
    hash_t       dg_reg;
    word_t       part_reg;

    logic        accept;
    logic        ram_we;
    word_t       ram_rdata;
    logic [6:0]  cnt_m1;
    logic [3:0]  widx;
    logic [3:0]  fill_word;
    logic [1:0]  fill_byte;
    logic        long_tail;
    logic [63:0] bit_len;
    word_t       pad_word;
    word_t       load_word;
    hash_t       base;
    hash_t       vars;
    hash_t       sum;
    sha1_ctrl_t  ctrl;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign fill_word = fill_reg[5:2];
    assign fill_byte = fill_reg[1:0];

    // With 56 or more pending bytes the length does not fit and a second block follows.
    assign long_tail = (fill_reg[5:3] == 3'b111);
    assign bit_len   = {total_reg, 3'b000};

    // The block buffer holds whole big-endian words; the word being filled lives in
    // part_reg and is written out together with its fourth byte.
    assign ram_we = accept && (s_tuser == OP_ABSORB) && (fill_byte == 2'd3);

    sha1_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_word),
        .wdata ({part_reg[31:8], s_tdata}),
        .raddr (cnt_reg[3:0]),
        .rdata (ram_rdata)
    );

    // The read for word j is issued at load count j, so the data seen at count c
    // belongs to word c-1.
    assign cnt_m1 = cnt_reg - 7'd1;
    assign widx   = cnt_m1[3:0];

    // The partly filled word: the bytes received so far, then the 0x80 marker,
    // then zeros.
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (2'(b) < fill_byte)
            begin
                pad_word[(3 - b) * 8 +: 8] = part_reg[(3 - b) * 8 +: 8];
            end
            else if (2'(b) == fill_byte)
            begin
                pad_word[(3 - b) * 8 +: 8] = 8'h80;
            end
            else
            begin
                pad_word[(3 - b) * 8 +: 8] = 8'h00;
            end
        end
    end

    // Word fed into the message schedule during the load phase.
    always_comb
    begin
        load_word = '0;
        case (kind_reg)
            KIND_ABS:
            begin
                load_word = ram_rdata;
            end
            KIND_PAD:
            begin
                if (widx < fill_word)
                begin
                    load_word = ram_rdata;
                end
                else if (widx == fill_word)
                begin
                    load_word = pad_word;
                end
                if (!long_tail && (widx == 4'd14))
                begin
                    load_word = bit_len[63:32];
                end
                else if (!long_tail && (widx == 4'd15))
                begin
                    load_word = bit_len[31:0];
                end
            end
            KIND_LEN:
            begin
                if (widx == 4'd14)
                begin
                    load_word = bit_len[63:32];
                end
                else if (widx == 4'd15)
                begin
                    load_word = bit_len[31:0];
                end
            end
            default:
            begin
                load_word = '0;
            end
        endcase
    end

    // The second padding block continues from the digest copy; everything else
    // starts from the running chaining value, which a digest never disturbs.
    assign base = (kind_reg == KIND_LEN) ? dg_reg : cv_reg;

    always_comb
    begin
        ctrl.load_vars = (state_reg == S_LOAD) && (cnt_reg == 7'd0);
        ctrl.shift_in  = (state_reg == S_LOAD) && (cnt_reg != 7'd0);
        ctrl.round_en  = (state_reg == S_ROUND);
        if (cnt_reg < 7'd20)
        begin
            ctrl.phase = 2'd0;
        end
        else if (cnt_reg < 7'd40)
        begin
            ctrl.phase = 2'd1;
        end
        else if (cnt_reg < 7'd60)
        begin
            ctrl.phase = 2'd2;
        end
        else
        begin
            ctrl.phase = 2'd3;
        end
    end

    sha1_round u_round (
        .clk     (clk),
        .ctrl    (ctrl),
        .base    (base),
        .word_in (load_word),
        .vars    (vars)
    );

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            sum[i] = base[i] + vars[i];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        oidx_next  = oidx_reg;
        cv_next    = cv_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_ABSORB:
                        begin
                            fill_next  = fill_reg + 6'd1;
                            total_next = total_reg + 61'd1;
                            if (fill_reg == 6'd63)
                            begin
                                kind_next  = KIND_ABS;
                                cnt_next   = '0;
                                state_next = S_LOAD;
                            end
                        end
                        OP_DIGEST:
                        begin
                            kind_next  = KIND_PAD;
                            cnt_next   = '0;
                            state_next = S_LOAD;
                        end
                        OP_RESTART:
                        begin
                            cv_next    = SHA1_IV;
                            fill_next  = '0;
                            total_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (cnt_reg == LOAD_END)
                begin
                    cnt_next   = '0;
                    state_next = S_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_ROUND:
            begin
                if (cnt_reg == LAST_ROUND)
                begin
                    cnt_next   = '0;
                    state_next = S_FINAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_FINAL:
            begin
                if (kind_reg == KIND_ABS)
                begin
                    cv_next    = sum;
                    state_next = S_IDLE;
                end
                else if ((kind_reg == KIND_PAD) && long_tail)
                begin
                    kind_next  = KIND_LEN;
                    state_next = S_LOAD;
                end
                else
                begin
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (oidx_reg == 3'd4)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_ABS;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            oidx_reg  <= '0;
            cv_reg    <= SHA1_IV;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            oidx_reg  <= oidx_next;
            cv_reg    <= cv_next;
        end
    end

    // Payload registers: the partial word and the digest copy.
    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == OP_ABSORB))
        begin
            part_reg[(3 - fill_byte) * 8 +: 8] <= s_tdata;
        end
        if ((state_reg == S_FINAL) && (kind_reg != KIND_ABS))
        begin
            dg_reg <= sum;
        end
    end

    // Result side: the digest words are presented straight from the digest copy.
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'b00000, oidx_reg, dg_reg[oidx_reg]};
    assign m_tlast  = (oidx_reg == 3'd4);

endmodule

### hdl/sha1_checker.sv
//------------------------------------------------------------------------------
// SHA-1 hasher port checker
// Watches the top-level ports and is bound to the core.
//------------------------------------------------------------------------------
`include "sha1_byte_stream_hasher_core_defines.svh"

module sha1_checker
    import sha1_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // A stalled digest word holds.
    `SHA1_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // No new request is taken while digest words are being delivered.
    `SHA1_ASSERT_IMPL(a_busy_out, clk, rst_n, m_tvalid, !s_tready)

    // The final word of a digest is word four.
    `SHA1_ASSERT_IMPL(a_last_idx, clk, rst_n, m_tvalid && m_tlast, m_tdata[34:32] == 3'd4)

    // A digest request starts a compression, so the input side goes busy.
    `SHA1_ASSERT_NEXT(a_digest_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == OP_DIGEST), !s_tready)

endmodule

bind sha1_byte_stream_hasher_core sha1_checker u_sha1_checker (.*);
